/* sv/intel_hex_record_encoder_defines.svh */
// Assertion macros for the Intel HEX record encoder.
// Included by the top level; no other dependencies.
`ifndef INTEL_HEX_RECORD_ENCODER_DEFINES_SVH
`define INTEL_HEX_RECORD_ENCODER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define IHX_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define IHX_ASSERT_NXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ihx_enc_pkg.sv */
// Shared types and constants for the Intel HEX record encoder.
// No dependencies.
package ihx_enc_pkg;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_FLUSH   = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;

  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_EXT   = 8'h04;
  localparam logic [7:0] REC_START = 8'h05;

  // One record byte as handed to the output stage.
  typedef struct packed {
    logic [7:0] value;
    logic       first;
    logic       final_byte;
    logic       last;
  } rec_byte_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (7'h30 + {3'd0, nib}) : (7'h37 + {3'd0, nib});
  endfunction

endpackage

/* sv/ihx_enc_line_mem.sv */
// Line buffer memory: one write port, one registered read port.
// Depends on nothing.
module ihx_enc_line_mem #(
  parameter int Depth = 32,
  parameter int Aw = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/ihx_enc_out.sv */
// Output stage: turns a record byte into two hex characters, one-entry output register.
// Depends on ihx_enc_pkg.
module ihx_enc_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ihx_enc_pkg::rec_byte_t in_byte_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // hex_high, hex_low, pad 2
  output logic [1:0]             m_axis_tuser,   // record_start, record_end
  output logic                   m_axis_tlast
);
  import ihx_enc_pkg::*;

  logic      valid_q;
  rec_byte_t byte_q;

  assign in_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) byte_q <= in_byte_i;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b00, hex_char(byte_q.value[3:0]), hex_char(byte_q.value[7:4])};
  assign m_axis_tuser  = {byte_q.final_byte, byte_q.first};
  assign m_axis_tlast  = byte_q.last;
endmodule

/* sv/intel_hex_record_encoder.sv */
// Top level of the Intel HEX (I32HEX) record encoder.
// Depends on ihx_enc_pkg, ihx_enc_line_mem, ihx_enc_out and the defines header.
//
// Usage:
//  s_axis carries one item: tdata = {data_byte, byte_address}, tuser = kind
//  (0 data byte, 1 flush, 2 trailer, 3 ignored). m_axis carries one record
//  byte per item as two ASCII hex digits; tuser marks the first byte (colon
//  before it) and the checksum byte (newline after it); tlast marks the
//  final record byte caused by one input item.
//  Configuration: cfg_we_i writes force_extended (0), start_enable (1) and
//  start_address (2); write only while idle.
// Sequencing: a data byte that only extends the line is accepted, then
//  stored into the line buffer. Each data record takes a segment check
//  (which also starts an extended address record when one is due), a
//  planning step, its header bytes, a line buffer read and its payload and
//  checksum bytes; a trailer record takes a planning step plus its bytes.
//  Accepting the item comes first and a finishing step last. Input is
//  taken only when the sequencer is idle and holds no pending byte.
// Reset: line and segment state, sequencer state and config registers clear;
//  the line buffer is not; only bytes written for the current line are read.
// Stall: when m_axis_tready is low and the output register is full, the
//  sequencer holds its byte; a one-entry output register parts the two sides.
`include "intel_hex_record_encoder_defines.svh"
module intel_hex_record_encoder #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // byte_address[31:0], data_byte[39:32]
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // hex_high[6:0], hex_low[13:7], zero pad
  output logic [1:0]  m_axis_tuser,   // record_start, record_end
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ihx_enc_pkg::*;

  localparam int Aw = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int Lw = $clog2(LINE_BYTES + 1);
  localparam logic [1:0] CFG_FORCE = 2'd0;
  localparam logic [1:0] CFG_SEN   = 2'd1;
  localparam logic [1:0] CFG_SADDR = 2'd2;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PLAN  = 3'd1;   // decide next record
  localparam logic [2:0] ST_HEAD  = 3'd2;   // length, addr hi, addr lo, type
  localparam logic [2:0] ST_BODY  = 3'd3;   // payload bytes
  localparam logic [2:0] ST_SUM   = 3'd4;   // checksum
  localparam logic [2:0] ST_FETCH = 3'd5;   // memory read latency

  // Record plans.
  localparam logic [2:0] PL_EXT1  = 3'd0;   // ext record, then first data
  localparam logic [2:0] PL_DAT1  = 3'd1;
  localparam logic [2:0] PL_EXT2  = 3'd2;
  localparam logic [2:0] PL_DAT2  = 3'd3;
  localparam logic [2:0] PL_START = 3'd4;
  localparam logic [2:0] PL_EOF   = 3'd5;
  localparam logic [2:0] PL_DONE  = 3'd6;

  logic        force_q, sen_q;
  logic [31:0] saddr_q;

  logic [31:0] laddr_q, laddr_d;
  logic [Lw-1:0] llen_q, llen_d;
  logic [15:0] seg_q, seg_d;
  logic        segk_q, segk_d;

  logic [2:0]  st_q, st_d, pl_q, pl_d;
  logic [1:0]  hidx_q, hidx_d;
  logic [7:0]  rlen_q, rlen_d, rtype_q, rtype_d, sum_q, sum_d;
  logic [15:0] raddr_q, raddr_d;
  logic [Lw-1:0] bcnt_q, bcnt_d, boff_q, boff_d;   // bytes sent, buffer offset
  logic [Lw-1:0] first_q, first_d;                // length of first part
  logic        after_q, after_d;                  // pending item after flush
  logic [31:0] pa_q, pa_d;                        // pending byte address
  logic [7:0]  pb_q, pb_d;
  logic        pend_q, pend_d;                    // pending byte to store

  logic        mem_we;
  logic [Aw-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd, mem_rd;

  rec_byte_t   ob;
  logic        ob_valid, ob_ready;

  logic [1:0]  kind;
  logic [31:0] in_addr;
  logic [7:0]  in_data;
  logic        in_acc;

  assign kind    = s_axis_tuser;
  assign in_addr = s_axis_tdata[31:0];
  assign in_data = s_axis_tdata[39:32];
  assign s_axis_tready = (st_q == ST_IDLE) && !pend_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q <= 1'b0;
      sen_q   <= 1'b0;
      saddr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FORCE: force_q <= cfg_data_i[0];
        CFG_SEN:   sen_q   <= cfg_data_i[0];
        CFG_SADDR: saddr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ihx_enc_line_mem #(.Depth(LINE_BYTES), .Aw(Aw)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // Byte of the current header by index.
  logic [7:0] head_byte;
  always_comb begin
    unique case (hidx_q)
      2'd0: head_byte = rlen_q;
      2'd1: head_byte = raddr_q[15:8];
      2'd2: head_byte = raddr_q[7:0];
      default: head_byte = rtype_q;
    endcase
  end

  // Payload of ext and start records comes from registers, not memory.
  logic [7:0] reg_byte;
  always_comb begin
    reg_byte = 8'h00;
    if (rtype_q == REC_EXT) begin
      reg_byte = (bcnt_q == '0) ? seg_q[15:8] : seg_q[7:0];
    end else if (rtype_q == REC_START) begin
      unique case (bcnt_q[1:0])
        2'd0: reg_byte = saddr_q[31:24];
        2'd1: reg_byte = saddr_q[23:16];
        2'd2: reg_byte = saddr_q[15:8];
        default: reg_byte = saddr_q[7:0];
      endcase
    end
  end

  // An ext record is never the last record of an item: its data record follows.
  logic [16:0] lo_end;
  logic [31:0] a2;
  logic        split, last_rec;
  always_comb begin
    lo_end = {1'b0, laddr_q[15:0]} + 17'(llen_q);
    split  = lo_end > 17'h10000;
    a2     = laddr_q + 32'(first_q);
    last_rec = (rtype_q != REC_EXT) &&
               ((pl_q == PL_DAT2) || (pl_q == PL_EOF) ||
                (pl_q == PL_DAT1 && !split));
  end

  always_comb begin
    st_d = st_q; pl_d = pl_q; hidx_d = hidx_q; rlen_d = rlen_q; rtype_d = rtype_q;
    raddr_d = raddr_q; sum_d = sum_q; bcnt_d = bcnt_q; boff_d = boff_q;
    first_d = first_q; after_d = after_q; pa_d = pa_q; pb_d = pb_q; pend_d = pend_q;
    laddr_d = laddr_q; llen_d = llen_q; seg_d = seg_q; segk_d = segk_q;
    mem_we = 1'b0; mem_wa = llen_q[Aw-1:0]; mem_wd = pb_q;
    mem_ra = boff_q[Aw-1:0];
    ob_valid = 1'b0; ob = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (pend_q) begin
          // Store the held byte, then flush if the line is full.
          pend_d = 1'b0;
          mem_we = 1'b1;
          if (llen_q == '0) laddr_d = pa_q;
          llen_d = llen_q + 1'b1;
          if (32'(llen_q) + 32'd1 >= 32'(LINE_BYTES)) begin
            st_d = ST_PLAN; pl_d = PL_EXT1; after_d = 1'b0;
          end
        end else if (in_acc) begin
          unique case (kind)
            KIND_DATA: begin
              pa_d = in_addr; pb_d = in_data;
              if (llen_q != '0 && laddr_q + 32'(llen_q) != in_addr) begin
                st_d = ST_PLAN; pl_d = PL_EXT1; after_d = 1'b1;
              end else begin
                pend_d = 1'b1;
              end
            end
            KIND_FLUSH: begin
              if (llen_q != '0) begin
                st_d = ST_PLAN; pl_d = PL_EXT1; after_d = 1'b0;
              end
            end
            KIND_TRAILER: begin
              st_d = ST_PLAN; pl_d = sen_q ? PL_START : PL_EOF;
            end
            default: ;
          endcase
        end
      end
      ST_PLAN: begin
        hidx_d = 2'd0; bcnt_d = '0;
        unique case (pl_q)
          PL_EXT1, PL_EXT2: begin
            logic [15:0] up;
            up = (pl_q == PL_EXT1) ? laddr_q[31:16] : a2[31:16];
            if (pl_q == PL_EXT1) first_d = split ? Lw'(17'h10000 - 17'(laddr_q[15:0])) : llen_q;
            if ((!segk_q && force_q) || up != seg_q) begin
              seg_d = up; rlen_d = 8'd2; rtype_d = REC_EXT; raddr_d = '0;
              sum_d = 8'd0; st_d = ST_HEAD;
            end
            segk_d = 1'b1;
            pl_d = pl_q + 3'd1;
          end
          PL_DAT1, PL_DAT2: begin
            rtype_d = REC_DATA;
            if (pl_q == PL_DAT1) begin
              rlen_d = 8'(first_q); raddr_d = laddr_q[15:0]; boff_d = '0;
            end else begin
              rlen_d = 8'(llen_q - first_q); raddr_d = a2[15:0]; boff_d = first_q;
            end
            sum_d = 8'd0; st_d = ST_HEAD;
          end
          PL_START: begin
            rlen_d = 8'd4; rtype_d = REC_START; raddr_d = '0; sum_d = 8'd0;
            st_d = ST_HEAD;
          end
          PL_EOF: begin
            rlen_d = 8'd0; rtype_d = REC_EOF; raddr_d = '0; sum_d = 8'd0;
            st_d = ST_HEAD;
          end
          default: begin
            // EOF clears line and segment; else advance, maybe store held byte.
            st_d = ST_IDLE;
            if (rtype_q == REC_EOF) begin
              laddr_d = '0; llen_d = '0; seg_d = '0; segk_d = 1'b0;
            end else begin
              laddr_d = laddr_q + 32'(llen_q); llen_d = '0;
              pend_d = after_q;
            end
          end
        endcase
      end
      ST_HEAD: begin
        ob_valid = 1'b1;
        ob.value = head_byte; ob.first = (hidx_q == 2'd0);
        if (ob_ready) begin
          sum_d = sum_q + head_byte;
          hidx_d = hidx_q + 2'd1;
          if (hidx_q == 2'd3) begin
            if (rlen_q == 8'd0) st_d = ST_SUM;
            else if (rtype_q == REC_DATA) st_d = ST_FETCH;
            else st_d = ST_BODY;
          end
        end
      end
      ST_FETCH: begin
        st_d = ST_BODY;
      end
      ST_BODY: begin
        logic [7:0] b;
        b = (rtype_q == REC_DATA) ? mem_rd : reg_byte;
        ob_valid = 1'b1; ob.value = b;
        if (ob_ready) begin
          sum_d = sum_q + b;
          bcnt_d = bcnt_q + 1'b1;
          boff_d = boff_q + 1'b1;
          mem_ra = Aw'(boff_q + 1'b1);
          if (8'(bcnt_q) + 8'd1 == rlen_q) st_d = ST_SUM;
        end
      end
      ST_SUM: begin
        ob_valid = 1'b1; ob.value = 8'd0 - sum_q; ob.final_byte = 1'b1;
        ob.last = last_rec;
        if (ob_ready) begin
          st_d = ST_PLAN;
          // After an ext record, hold the plan so its data record follows.
          if (rtype_q == REC_EXT) pl_d = pl_q;
          else if (pl_q == PL_START) pl_d = PL_EOF;
          else if (last_rec) pl_d = PL_DONE;
          else pl_d = PL_EXT2;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pl_q <= PL_DONE; pend_q <= 1'b0; after_q <= 1'b0;
      laddr_q <= '0; llen_q <= '0; seg_q <= '0; segk_q <= 1'b0;
      hidx_q <= '0; bcnt_q <= '0; boff_q <= '0; rtype_q <= REC_DATA;
    end else begin
      st_q <= st_d; pl_q <= pl_d; pend_q <= pend_d; after_q <= after_d;
      laddr_q <= laddr_d; llen_q <= llen_d; seg_q <= seg_d; segk_q <= segk_d;
      hidx_q <= hidx_d; bcnt_q <= bcnt_d; boff_q <= boff_d; rtype_q <= rtype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rlen_q <= rlen_d; raddr_q <= raddr_d; sum_q <= sum_d; first_q <= first_d;
    pa_q <= pa_d; pb_q <= pb_d;
  end

  ihx_enc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (ob_valid),
    .in_ready_o    (ob_ready),
    .in_byte_i     (ob),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `IHX_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, 32'(llen_q) <= 32'(LINE_BYTES), "line length over capacity")
  `IHX_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != ST_IDLE, !s_axis_tready, "input taken while busy")
  `IHX_ASSERT_NXT(a_eof_clears, clk_i, rst_ni, st_q == ST_PLAN && pl_q == PL_DONE && rtype_q == REC_EOF, llen_q == '0 && !segk_q, "trailer did not clear line state")
endmodule

/* tb/tb_top.sv */
// Testbench for the Intel HEX record encoder: drives addressed bytes, flushes
// and trailers, predicts every record byte and checks each output item.
// Depends on ihx_enc_pkg and intel_hex_record_encoder.
module tb_top;
  import ihx_enc_pkg::*;

  localparam int LINE_LEN = 32;
  localparam int CFG_FORCE_EXT = 0;
  localparam int CFG_START_EN = 1;
  localparam int CFG_START_ADDR = 2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [6:0] hi;
    logic [6:0] lo;
    logic       rec_start;
    logic       rec_end;
    logic       last;
  } hex_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  intel_hex_record_encoder dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the line, segment and registers.
  logic [7:0]  line_q [LINE_LEN];
  logic [31:0] line_base;
  int unsigned line_cnt;
  logic [15:0] seg_hi;
  bit          seg_valid;
  bit          force_ext;
  bit          start_en;
  logic [31:0] start_addr;

  hex_char_t   expected_chars[$];
  hex_char_t   item_chars[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;   // long receiver stall while set
  bit          burst_mode = 1'b1; // sender idles between bursts when set

  function automatic logic [6:0] digit(input logic [3:0] n);
    return (n < 4'd10) ? 7'h30 + {3'd0, n} : 7'h37 + {3'd0, n};
  endfunction

  function automatic void push_char(input logic [7:0] b, input bit f, input bit e);
    hex_char_t c;
    c.hi = digit(b[7:4]);
    c.lo = digit(b[3:0]);
    c.rec_start = f;
    c.rec_end = e;
    c.last = 1'b0;
    if (item_chars.size() < 56) item_chars.push_back(c);
  endfunction

  // Emit one record; data bytes come from a queue.
  function automatic void emit_record(input logic [7:0] len, input logic [15:0] addr,
                                      input logic [7:0] rtype, input logic [7:0] d[$]);
    logic [7:0] sum;
    sum = len + addr[15:8] + addr[7:0] + rtype;
    push_char(len, 1, 0);
    push_char(addr[15:8], 0, 0);
    push_char(addr[7:0], 0, 0);
    push_char(rtype, 0, 0);
    foreach (d[i]) begin
      push_char(d[i], 0, 0);
      sum += d[i];
    end
    push_char(-sum, 0, 1);
  endfunction

  function automatic void emit_data(input logic [31:0] addr, input int first, input int n);
    logic [7:0] d[$];
    logic [15:0] up;
    up = addr[31:16];
    if ((!seg_valid && force_ext) || up != seg_hi) begin
      d = '{up[15:8], up[7:0]};
      emit_record(8'd2, 16'd0, REC_EXT, d);
      seg_hi = up;
    end
    seg_valid = 1'b1;
    d = {};
    for (int i = 0; i < n; i++) d.push_back(line_q[first + i]);
    emit_record(n[7:0], addr[15:0], REC_DATA, d);
  endfunction

  function automatic void flush_pending();
    int unsigned lo, head;
    if (line_cnt == 0) return;
    lo = line_base[15:0];
    if (lo + line_cnt > 32'h10000) begin
      head = 32'h10000 - lo;
      emit_data(line_base, 0, head);
      emit_data(line_base + head, head, line_cnt - head);
    end else begin
      emit_data(line_base, 0, line_cnt);
    end
    line_base += line_cnt;
    line_cnt = 0;
  endfunction

  function automatic void clear_line();
    line_base = '0;
    line_cnt = 0;
    seg_hi = '0;
    seg_valid = 1'b0;
  endfunction

  // Work out the record bytes caused by one item and queue them.
  function automatic void predict_item(input logic [1:0] kind, input logic [31:0] addr,
                                       input logic [7:0] data);
    logic [7:0] d[$];
    item_chars = {};
    case (kind)
      KIND_DATA: begin
        if (line_cnt != 0 && line_base + line_cnt != addr) flush_pending();
        if (line_cnt == 0) line_base = addr;
        line_q[line_cnt] = data;
        line_cnt++;
        if (line_cnt >= LINE_LEN) flush_pending();
      end
      KIND_FLUSH: flush_pending();
      KIND_TRAILER: begin
        if (start_en) begin
          d = '{start_addr[31:24], start_addr[23:16], start_addr[15:8], start_addr[7:0]};
          emit_record(8'd4, 16'd0, REC_START, d);
        end
        d = {};
        emit_record(8'd0, 16'd0, REC_EOF, d);
        clear_line();
      end
      default: ;
    endcase
    if (item_chars.size() > 0) item_chars[item_chars.size() - 1].last = 1'b1;
    foreach (item_chars[i]) expected_chars.push_back(item_chars[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  // Send one item; idle gaps fall between bursts. Valid stays high after the
  // item is taken until the next item or an idle stretch replaces it.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] addr,
                           input logic [7:0] data);
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, addr, data);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_cfg(input int idx, input logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx[1:0];
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FORCE_EXT: force_ext = val[0];
      CFG_START_EN: start_en = val[0];
      default: start_addr = val;
    endcase
  endtask

  // Receiver: random stall pattern, and a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) || cycles[9];
  end

  // Check each accepted record byte against the oldest expectation.
  always @(posedge clk_i) begin
    hex_char_t exp_c;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("record byte with nothing expected");
      end else begin
        exp_c = expected_chars.pop_front();
        if (m_axis_tdata[6:0] != exp_c.hi) report_mismatch("hex_high");
        if (m_axis_tdata[13:7] != exp_c.lo) report_mismatch("hex_low");
        if (m_axis_tuser[0] != exp_c.rec_start) report_mismatch("record_start");
        if (m_axis_tuser[1] != exp_c.rec_end) report_mismatch("record_end");
        if (m_axis_tlast != exp_c.last) report_mismatch("last");
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(KIND_FLUSH, 0, 0);                 // empty flush, no output
    send_item(KIND_UNUSED, 32'hFFFFFFFF, 8'hFF); // ignored kind
    send_item(KIND_DATA, 32'h0000_0000, 8'h00);
    send_item(KIND_DATA, 32'h0000_0001, 8'hFF);
    send_item(KIND_DATA, 32'h0000_0010, 8'hA5);  // gap flushes
    send_item(KIND_FLUSH, 0, 0);
    send_item(KIND_DATA, 32'hFFFF_FFFE, 8'h5A);  // wrap past 2^32
    send_item(KIND_DATA, 32'hFFFF_FFFF, 8'h3C);
    send_item(KIND_DATA, 32'h0000_0000, 8'hC3);
    send_item(KIND_FLUSH, 0, 0);
    send_item(KIND_DATA, 32'h1234_FFFF, 8'h11);  // 64K split
    send_item(KIND_DATA, 32'h1235_0000, 8'h22);
    send_item(KIND_FLUSH, 0, 0);
    send_item(KIND_DATA, 32'h5555_5555, 8'h77);
    send_item(KIND_TRAILER, 0, 0);               // pending byte dropped
  endtask

  task automatic test_full_line();
    for (int i = 0; i < LINE_LEN; i++)
      send_item(KIND_DATA, 32'h0002_FFF0 + i, 8'($urandom_range(0, 255)));
    send_item(KIND_TRAILER, 0, 0);
  endtask

  // Hold the receiver off while items keep coming so the block stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_item(KIND_DATA, 32'h0040_0000 + i, i[7:0]);
    join
    send_item(KIND_FLUSH, 0, 0);
    drain();   // sender pauses until all results are in
  endtask

  task automatic test_random(input int n);
    logic [31:0] a;
    int run;
    a = $urandom;
    for (int i = 0; i < n; ) begin
      burst_mode = ($urandom_range(0, 3) != 0);
      run = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) a = $urandom;
      else if ($urandom_range(0, 2) == 0) a = {a[31:16], 16'(16'hFFFF - $urandom_range(0, 8))};
      for (int k = 0; k < run && i < n; k++, i++) begin
        send_item(KIND_DATA, a, 8'($urandom_range(0, 255)));
        a += ($urandom_range(0, 15) == 0) ? $urandom_range(2, 9) : 1;
      end
      case ($urandom_range(0, 9))
        0: send_item(KIND_TRAILER, $urandom, 8'($urandom));
        1: send_item(KIND_UNUSED, $urandom, 8'($urandom));
        2, 3, 4: send_item(KIND_FLUSH, $urandom, 8'($urandom));
        default: ;
      endcase
    end
    send_item(KIND_FLUSH, 0, 0);
    send_item(KIND_TRAILER, 0, 0);
  endtask

  initial begin
    clear_line();
    force_ext = 0;
    start_en = 0;
    start_addr = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_cfg(CFG_FORCE_EXT, 1);
    write_cfg(CFG_START_EN, 1);
    write_cfg(CFG_START_ADDR, 32'hFFFF_FFFF);
    test_directed();
    test_full_line();
    write_cfg(CFG_START_ADDR, 32'h0);
    test_backpressure();
    send_item(KIND_TRAILER, 0, 0);
    write_cfg(CFG_START_ADDR, $urandom);
    test_random(20);
    write_cfg(CFG_FORCE_EXT, 0);
    write_cfg(CFG_START_EN, 0);
    test_random(20);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* intel_hex_record_encoder.f */
+incdir+sv
sv/ihx_enc_pkg.sv
sv/ihx_enc_line_mem.sv
sv/ihx_enc_out.sv
sv/intel_hex_record_encoder.sv
tb/tb_top.sv
